// ----- hdl/tct_pkg.sv -----
// Package for the touch chord tracker: item structs, operation and status codes,
// and the command and status groups between controller and datapath.
// No dependencies.
package tct_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TID_W     = 32;
  localparam int MASK_W    = 6;

  // Operation codes of an input item.
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_BADID = 2'd2;
  localparam logic [1:0] ST_HALT  = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [TID_W-1:0]  touch_id;
    logic              hit;
    logic [MASK_W-1:0] button_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              chord_valid;
    logic [MASK_W-1:0] chord_bits;
    logic [MASK_W-1:0] pressed_bits;
    logic              shutdown_flag;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic match;
    logic pick;
    logic commit;
  } tct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } tct_sts_t;

endpackage

// ----- hdl/tct_ctrl.sv -----
// Controller of the touch chord tracker: sequences one item through the
// match, pick, read and commit steps of the datapath. Depends on tct_pkg.
module tct_ctrl
  import tct_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tct_sts_t sts,
  output tct_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_PICK  = 5'b00100,
    S_READ  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_MATCH;
      end
      S_MATCH: state_nxt = S_PICK;
      S_PICK:  state_nxt = S_READ;
      S_READ:  state_nxt = S_DONE;
      S_DONE: begin
        // Hold the finished item until the output register can take it.
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.match  = (state_r == S_MATCH);
  assign cmd.pick   = (state_r == S_PICK);
  assign cmd.commit = (state_r == S_DONE) && sts.out_free;

endmodule

// ----- hdl/tct_dp.sv -----
// Datapath of the touch chord tracker: slot id registers with parallel compare,
// hit and mask memory, held-touch counters and the output register.
// Depends on tct_pkg.
module tct_dp
  import tct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tct_cmd_t  cmd,
  output tct_sts_t  sts,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  in_item_t          item_r;
  logic [TID_W-1:0]  id_r [SLOTS];
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  match_r, free_r;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              found_r;
  logic [MASK_W:0]   slot_mem_r [SLOTS];
  logic [MASK_W:0]   rd_r;
  logic [CW-1:0]     bit_cnt_r [MASK_W];
  logic [CW-1:0]     bit_cnt_nxt [MASK_W];
  logic [CW-1:0]     miss_cnt_r, miss_cnt_nxt;
  logic              armed_r, armed_nxt;
  logic              halted_r, halted_nxt;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [SLOTS-1:0]  sel_vec, low_vec;
  logic [1:0]        status;
  logic              chord_valid;
  logic [MASK_W-1:0] chord_bits, pressed_cur, pressed_nxt;
  logic              begin_ok, end_ok, rd_hit;
  logic [MASK_W-1:0] rd_mask, new_mask;

  // Lowest set bit of the candidate vector gives the slot.
  always_comb begin
    sel_vec = (item_r.operation == OP_END) ? match_r : free_r;
    low_vec = sel_vec & (~sel_vec + {{(SLOTS-1){1'b0}}, 1'b1});
    idx_nxt = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (low_vec[i]) idx_nxt = idx_nxt | IW'(i);
    end
  end

  assign rd_hit   = rd_r[MASK_W];
  assign rd_mask  = rd_r[MASK_W-1:0];
  assign new_mask = item_r.hit ? item_r.button_mask : '0;

  always_comb begin
    status      = ST_OK;
    chord_valid = 1'b0;
    chord_bits  = '0;
    begin_ok    = 1'b0;
    end_ok      = 1'b0;
    halted_nxt  = halted_r;
    armed_nxt   = armed_r;
    valid_nxt   = valid_r;
    for (int b = 0; b < MASK_W; b++) begin
      pressed_cur[b] = (bit_cnt_r[b] != '0);
    end
    if (halted_r) begin
      status = ST_HALT;
    end else if (item_r.operation == OP_BEGIN) begin
      if (item_r.touch_id == '0) begin
        status = ST_BADID;
      end else if (!found_r) begin
        status = ST_FULL;
      end else begin
        begin_ok = cmd.commit;
      end
    end else if (item_r.operation == OP_END) begin
      if (item_r.touch_id == '0 || !found_r) begin
        status = ST_BADID;
      end else if (miss_cnt_r >= CW'(2)) begin
        // Two missed touches held: latch shutdown and keep the slot.
        halted_nxt = cmd.commit ? 1'b1 : halted_r;
      end else begin
        end_ok = cmd.commit;
        if (armed_r) begin
          chord_valid = 1'b1;
          chord_bits  = pressed_cur;
        end
      end
    end

    if (begin_ok) begin
      valid_nxt[idx_r] = 1'b1;
      if (item_r.hit) armed_nxt = 1'b1;
    end
    if (end_ok) begin
      valid_nxt[idx_r] = 1'b0;
      armed_nxt        = 1'b0;
    end

    miss_cnt_nxt = miss_cnt_r + CW'(begin_ok && !item_r.hit) - CW'(end_ok && !rd_hit);
    for (int b = 0; b < MASK_W; b++) begin
      bit_cnt_nxt[b] = bit_cnt_r[b] + CW'(begin_ok && new_mask[b])
                       - CW'(end_ok && rd_mask[b]);
      pressed_nxt[b] = (bit_cnt_nxt[b] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.match) begin
      for (int i = 0; i < SLOTS; i++) begin
        match_r[i] <= valid_r[i] && (id_r[i] == item_r.touch_id);
      end
      free_r <= ~valid_r;
    end
    if (cmd.pick) begin
      idx_r   <= idx_nxt;
      found_r <= |sel_vec;
    end
    rd_r <= slot_mem_r[idx_r];
    if (begin_ok) begin
      slot_mem_r[idx_r] <= {item_r.hit, new_mask};
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (begin_ok && idx_r == IW'(i)) id_r[i] <= item_r.touch_id;
    end
    if (cmd.commit) begin
      out_r.status        <= status;
      out_r.chord_valid   <= chord_valid;
      out_r.chord_bits    <= chord_bits;
      out_r.pressed_bits  <= pressed_nxt;
      out_r.shutdown_flag <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      miss_cnt_r  <= '0;
      armed_r     <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int b = 0; b < MASK_W; b++) begin
        bit_cnt_r[b] <= '0;
      end
    end else begin
      valid_r    <= valid_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      armed_r    <= armed_nxt;
      halted_r   <= halted_nxt;
      for (int b = 0; b < MASK_W; b++) begin
        bit_cnt_r[b] <= bit_cnt_nxt[b];
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

`ifndef SYNTH
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("shutdown flag cleared without reset");

  a_halt_keeps_slots: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(halted_r) |-> $stable(valid_r))
    else $error("slot occupancy changed when shutdown latched");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result committed over an untaken result");

  a_no_chord_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.chord_valid) |-> (out_r.chord_bits == '0))
    else $error("chord bits set without a chord");
`endif

endmodule

// ----- hdl/touch_chord_tracker.sv -----
// Touch chord tracker, top level.
// Each transferred item passes the match, pick, memory read and commit steps in turn.
// A new item is taken only after the last one is committed, and the commit waits
// while the output register is still held by a stalled result.
// Reset: synchronous and active low; all slots free, chord disarmed, no shutdown.
module touch_chord_tracker
  import tct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // The controller steps each item through four stages. The datapath holds
  // the slot ids in registers so that all slots are compared in parallel, and
  // keeps each slot's hit flag and mask in a small memory read at the chosen
  // slot. Pressed bits and the count of missed touches are kept as running
  // counters, so no sweep over the slots is needed at release.
  // The output register lets a finished result wait while the next transfer
  // is already being taken in.
  tct_cmd_t cmd;
  tct_sts_t sts;

  tct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tct_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/touch_chord_tracker_checker.sv -----
// Scoreboard for the touch chord tracker: watches both channels, predicts each result
// from its own copy of the slot table and compares field by field.
// Depends on tct_pkg.
`timescale 1ns / 100ps

module touch_chord_tracker_checker
  import tct_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        open_count
);

  logic [TID_W-1:0]  touch_ids  [SLOTS];
  logic              touch_hit  [SLOTS];
  logic [MASK_W-1:0] touch_mask [SLOTS];
  logic              chord_armed;
  logic              shut_down;
  out_item_t         due_reports [$];

  // OR of the masks of every held touch that landed on a button.
  function automatic logic [MASK_W-1:0] held_mask();
    logic [MASK_W-1:0] bits;
    int i;
    bits = '0;
    for (i = 0; i < SLOTS; i++)
      if (touch_ids[i] != '0 && touch_hit[i]) bits |= touch_mask[i];
    return bits;
  endfunction

  task automatic predict_touch(input in_item_t t, output out_item_t r);
    int i;
    int slot;
    int misses;
    r      = '0;
    slot   = -1;
    misses = 0;
    if (shut_down) begin
      r.status = ST_HALT;
    end else if (t.operation == OP_BEGIN) begin
      if (t.touch_id == '0) begin
        r.status = ST_BADID;
      end else begin
        for (i = SLOTS - 1; i >= 0; i--)
          if (touch_ids[i] == '0) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          touch_ids[slot]  = t.touch_id;
          touch_hit[slot]  = t.hit;
          touch_mask[slot] = t.hit ? t.button_mask : '0;
          if (t.hit) chord_armed = 1'b1;
        end
      end
    end else if (t.operation == OP_END) begin
      if (t.touch_id != '0)
        for (i = SLOTS - 1; i >= 0; i--)
          if (touch_ids[i] == t.touch_id) slot = i;
      if (slot < 0) begin
        r.status = ST_BADID;
      end else begin
        for (i = 0; i < SLOTS; i++)
          if (touch_ids[i] != '0 && !touch_hit[i]) misses++;
        if (misses >= 2) begin
          // Two stray touches held at a release: latch shutdown, keep the slot.
          shut_down = 1'b1;
        end else begin
          if (chord_armed) begin
            r.chord_valid = 1'b1;
            r.chord_bits  = held_mask();
            chord_armed   = 1'b0;
          end
          touch_ids[slot]  = '0;
          touch_hit[slot]  = 1'b0;
          touch_mask[slot] = '0;
        end
      end
    end
    r.pressed_bits  = held_mask();
    r.shutdown_flag = shut_down;
  endtask

  task automatic flag_result(input string why, input out_item_t want, input out_item_t got);
    if (fail_count < 10)
      $display("%0t %s: expected st=%0d cv=%0b cb=%02h pb=%02h sd=%0b, got st=%0d cv=%0b cb=%02h pb=%02h sd=%0b",
               $time, why, want.status, want.chord_valid, want.chord_bits, want.pressed_bits,
               want.shutdown_flag, got.status, got.chord_valid, got.chord_bits,
               got.pressed_bits, got.shutdown_flag);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    int i;
    if (!rst_n) begin
      for (i = 0; i < SLOTS; i++) begin
        touch_ids[i]  = '0;
        touch_hit[i]  = 1'b0;
        touch_mask[i] = '0;
      end
      chord_armed = 1'b0;
      shut_down   = 1'b0;
      due_reports.delete();
      fail_count  = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_touch(in_data, want);
        due_reports.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          flag_result("unexpected result", '0, out_data);
        end else begin
          want = due_reports.pop_front();
          if (out_data.status !== want.status || out_data.chord_valid !== want.chord_valid ||
              out_data.chord_bits !== want.chord_bits ||
              out_data.pressed_bits !== want.pressed_bits ||
              out_data.shutdown_flag !== want.shutdown_flag)
            flag_result("result mismatch", want, out_data);
        end
      end
    end
    open_count = due_reports.size();
  end

endmodule

// ----- sim/touch_chord_tracker_tb.sv -----
// Top-level testbench for the touch chord tracker: clock, reset, touch stimulus,
// result-side back-pressure, watchdog and verdict.
// Depends on tct_pkg, touch_chord_tracker and touch_chord_tracker_checker.
`timescale 1ns / 100ps

module touch_chord_tracker_tb
  import tct_pkg::*;
();

  // The fourth operation code is undefined and must behave like an update.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int RANDOM_TOUCHES = 860;
  localparam int CALM_TAIL      = 120;   // last random transfers run with no idling
  localparam int HOLD_AT        = 200;   // random transfer at which the long hold-off starts
  localparam int HOLD_CYCLES    = 150;
  localparam int QUIET_LIMIT    = 2000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES   = 20;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        open_count;

  // Idling controls, set by the stimulus process and read by the two drivers.
  bit src_gaps;
  bit sink_gaps;
  int hold_asked;
  int hold_given;

  // The stimulus keeps its own picture of the slot table so that ends can aim at live
  // touches and so that no more than one stray touch is ever held during the main run.
  // Two held strays would latch the sticky shutdown, which only the closing part may do.
  logic [TID_W-1:0] held_id   [SLOTS_DEF];
  logic             held_miss [SLOTS_DEF];
  bit               filling;

  touch_chord_tracker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  touch_chord_tracker_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side. Stall changes only on the falling edge, one assignment per edge. A
  // hold-off request from the stimulus overrides the random bursts and is timed here.
  initial begin : result_sink
    int unsigned stall_left;
    out_stall  = 1'b0;
    hold_given = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_given != hold_asked) begin
          stall_left = HOLD_CYCLES;
          hold_given++;
        end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 13);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // The run is abandoned once neither channel has seen a transfer for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic in_item_t make_touch(logic [1:0] op, logic [TID_W-1:0] id, logic hit,
                                          logic [MASK_W-1:0] mask);
    in_item_t t;
    t.operation   = op;
    t.touch_id    = id;
    t.hit         = hit;
    t.button_mask = mask;
    return t;
  endfunction

  // Lowest slot holding the given id; an id of zero finds the lowest free slot.
  function automatic int slot_of(logic [TID_W-1:0] id);
    int i;
    int found;
    found = -1;
    for (i = SLOTS_DEF - 1; i >= 0; i--)
      if (held_id[i] == id) found = i;
    return found;
  endfunction

  function automatic int count_held(bit misses_only);
    int i;
    int n;
    n = 0;
    for (i = 0; i < SLOTS_DEF; i++)
      if (held_id[i] != '0 && (!misses_only || held_miss[i])) n++;
    return n;
  endfunction

  // A random occupied slot; only called while at least one touch is held.
  function automatic int live_slot();
    int s;
    do s = $urandom_range(0, SLOTS_DEF - 1); while (held_id[s] == '0);
    return s;
  endfunction

  // Updates the slot picture, then offers the item until it is transferred. Called on a
  // falling edge and returns on the falling edge after the transfer, so valid is raised,
  // held or dropped exactly once per edge.
  task automatic send_touch(input in_item_t t);
    int s;
    int gap;
    if (t.touch_id != '0) begin
      if (t.operation == OP_BEGIN) begin
        s = slot_of('0);
        if (s >= 0) begin
          held_id[s]   = t.touch_id;
          held_miss[s] = !t.hit;
        end
      end else if (t.operation == OP_END) begin
        s = slot_of(t.touch_id);
        if (s >= 0 && count_held(1'b1) < 2) held_id[s] = '0;
      end
    end
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Most random items are begins and ends of live touches; the rest are updates, the
  // undefined operation, the invalid id and ends of ids that were never seen. The mix
  // swings between filling and draining so that the table regularly runs full.
  task automatic random_touch(output in_item_t t);
    int pick;
    int s;
    logic [TID_W-1:0] id;
    logic hit;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 29) == 0) filling = !filling;
    hit = 1'b1;
    do id = $urandom; while (id == '0);
    t = make_touch(OP_UPDATE, $urandom, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    if (pick < 12) begin
      case (pick % 6)
        0: begin
          t.operation = OP_UPDATE;
        end
        1: begin
          t.operation = OP_SPARE;
        end
        2: begin
          t.operation = OP_BEGIN;
          t.touch_id  = '0;
        end
        3: begin
          t.operation = OP_END;
          t.touch_id  = '0;
        end
        default: begin
          t.operation = OP_END;   // a random id is almost never live
        end
      endcase
    end else if (count_held(1'b0) == 0 || pick < (filling ? 70 : 35)) begin
      // Now and then a second touch reuses an id that is already held.
      if (count_held(1'b0) != 0 && $urandom_range(0, 15) == 0) id = held_id[live_slot()];
      if (count_held(1'b1) == 0 && $urandom_range(0, 3) == 0) hit = 1'b0;
      t = make_touch(OP_BEGIN, id, hit, 6'($urandom_range(0, 63)));
    end else begin
      s = live_slot();
      t = make_touch(OP_END, held_id[s], 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
    end
  endtask

  initial begin : stimulus
    int n;
    int s;
    in_item_t t;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    src_gaps   = 1'b0;
    sink_gaps  = 1'b0;
    hold_asked = 0;
    filling    = 1'b1;
    for (n = 0; n < SLOTS_DEF; n++) begin
      held_id[n]   = '0;
      held_miss[n] = 1'b0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Updates and the undefined code carry extreme fields and must change
    // nothing; a begin with the invalid id is refused.
    send_touch(make_touch(OP_UPDATE, '0, 1'b0, '0));
    send_touch(make_touch(OP_SPARE, '1, 1'b1, '1));
    send_touch(make_touch(OP_BEGIN, '0, 1'b1, '1));

    // Fill every slot: the largest id with a full mask, a hit with an empty mask, a stray
    // touch whose mask must be dropped, and the same id held twice.
    send_touch(make_touch(OP_BEGIN, '1, 1'b1, '1));
    send_touch(make_touch(OP_BEGIN, 32'd1, 1'b1, '0));
    send_touch(make_touch(OP_BEGIN, 32'd2, 1'b0, 6'h2A));
    send_touch(make_touch(OP_BEGIN, 32'd7, 1'b1, 6'h01));
    send_touch(make_touch(OP_BEGIN, 32'd7, 1'b1, 6'h02));
    for (n = 0; n < SLOTS_DEF - 5; n++)
      send_touch(make_touch(OP_BEGIN, 32'h10 + n, 1'b1, 6'h04 << (n % 4)));

    // Table full, then ends with the invalid id and with an id that is not held.
    send_touch(make_touch(OP_BEGIN, 32'h55, 1'b1, 6'h3F));
    send_touch(make_touch(OP_END, '0, 1'b0, '0));
    send_touch(make_touch(OP_END, 32'h1234_5678, 1'b1, '1));

    // First release emits the chord; the next ones find it disarmed. The duplicated id
    // releases its lower slot first.
    send_touch(make_touch(OP_END, 32'd1, 1'b0, '0));
    send_touch(make_touch(OP_END, 32'd2, 1'b0, '0));
    send_touch(make_touch(OP_END, 32'd7, 1'b0, '0));

    // Random part with idling on both sides. Early on the receiver holds off for a long
    // stretch while the sender keeps offering, so the block backs up and stalls its input.
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    for (n = 0; n < RANDOM_TOUCHES; n++) begin
      if (n == HOLD_AT) begin
        hold_asked++;
        src_gaps = 1'b0;
      end
      if (n == HOLD_AT + 60) src_gaps = 1'b1;
      if (n == RANDOM_TOUCHES - CALM_TAIL) begin
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
      end
      random_touch(t);
      send_touch(t);
    end

    // Closing part: release everything, then hold two stray touches and release one of
    // them, which latches the shutdown. Every later item must be refused.
    while (count_held(1'b0) != 0) begin
      s = 0;
      while (held_id[s] == '0) s++;
      send_touch(make_touch(OP_END, held_id[s], 1'b0, '0));
    end
    send_touch(make_touch(OP_BEGIN, 32'h0A11, 1'b1, 6'h09));
    send_touch(make_touch(OP_BEGIN, 32'h0B22, 1'b0, '0));
    send_touch(make_touch(OP_BEGIN, 32'h0C33, 1'b0, 6'h11));
    send_touch(make_touch(OP_END, 32'h0B22, 1'b0, '0));
    send_touch(make_touch(OP_BEGIN, 32'h0D44, 1'b1, '1));
    send_touch(make_touch(OP_END, 32'h0A11, 1'b0, '0));
    send_touch(make_touch(OP_UPDATE, 32'h0C33, 1'b1, '1));
    in_valid <= 1'b0;

    // Every item yields one result; wait for the last, then a little longer so that any
    // stray extra result would still be caught by the checker.
    while (open_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && open_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tct_pkg.sv
hdl/tct_ctrl.sv
hdl/tct_dp.sv
hdl/touch_chord_tracker.sv
sim/touch_chord_tracker_checker.sv
sim/touch_chord_tracker_tb.sv
